// ===== src/tlcrg_pkg.sv =====
// Shared types, register codes and normalize helpers for the thin-lens ray generator.
// No dependencies; used by tlcrg_rotate and thin_lens_camera_ray_generator_unit.
package tlcrg_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int IDX_W          = 12;
   localparam int Q_FRAC         = 14;
   localparam int NORM_W         = 64;
   localparam int POS_W          = $clog2(NORM_W);
   localparam int NORM_TOP       = 29;
   localparam logic [63:0] ROT_RESET = 64'd16384;
   localparam logic signed [31:0] NORM_EDGE = 32'shC000_0000;

   typedef enum logic [2:0] {
      CSR_ROTATION    = 3'd0,
      CSR_POS_X       = 3'd1,
      CSR_POS_Y       = 3'd2,
      CSR_POS_Z       = 3'd3,
      CSR_VIEW_OFFSET = 3'd4,
      CSR_STEP_X      = 3'd5,
      CSR_STEP_Y      = 3'd6,
      CSR_DEFOCUS     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [IDX_W-1:0]   pixel_col;
      logic [IDX_W-1:0]   pixel_row;
      logic [15:0]        jitter_x;
      logic [15:0]        jitter_y;
      logic signed [15:0] disk_x;
      logic signed [15:0] disk_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } rsp_type;

   function automatic logic [NORM_W-1:0] mag_of(input logic signed [NORM_W-1:0] x);
      return x[NORM_W-1] ? NORM_W'(-x) : NORM_W'(x);
   endfunction

   // position of the highest set bit, zero for an all-zero word
   function automatic logic [POS_W-1:0] lead_pos(input logic [NORM_W-1:0] m);
      logic [POS_W-1:0] p;
      p = '0;
      for (int i = 0; i < NORM_W; i++) begin
         if (m[i]) p = POS_W'(i);
      end
      return p;
   endfunction

   // brings the top bit to NORM_TOP: halving floors, doubling is exact
   function automatic logic signed [31:0] norm_shift(input logic signed [NORM_W-1:0] x,
                                                     input logic [POS_W-1:0] p);
      logic signed [NORM_W-1:0] y;
      if (p >= POS_W'(NORM_TOP)) begin
         y = x >>> (p - POS_W'(NORM_TOP));
      end else begin
         y = x <<< (POS_W'(NORM_TOP) - p);
      end
      return signed'(y[31:0]);
   endfunction

endpackage

// ===== src/tlcrg_rotate.sv =====
// Four-stage quaternion rotation v' = v + 2(w*a + b), a = u x v, b = u x a.
// Depends on tlcrg_pkg for the fraction width.
module tlcrg_rotate #(
   parameter int IN_W = 31
) (
   input  logic                   clock,
   input  logic [63:0]            quat,
   input  logic signed [IN_W-1:0] v_in [3],
   output logic signed [IN_W+8:0] r_out [3]
);

   localparam int P_W  = IN_W + 16;
   localparam int D_W  = IN_W + 17;
   localparam int A_W  = IN_W + 3;
   localparam int PB_W = A_W + 16;
   localparam int DB_W = PB_W + 1;
   localparam int R_W  = IN_W + 9;

   logic signed [15:0] qw, qx, qy, qz;
   assign qw = quat[15:0];
   assign qx = quat[31:16];
   assign qy = quat[47:32];
   assign qz = quat[63:48];

   logic signed [P_W-1:0]  pa_in [6], pa_ff [6];
   logic signed [A_W-1:0]  a_in [3], a_ff [3];
   logic signed [PB_W-1:0] pb_in [6], pb_ff [6];
   logic signed [PB_W-1:0] wa_in [3], wa_ff [3];
   logic signed [R_W-1:0]  r_in [3], r_ff [3];
   logic signed [IN_W-1:0] v1_ff [3], v2_ff [3], v3_ff [3];
   logic signed [DB_W-1:0] db [3];

   // stage 1: cross product terms
   always_comb begin
      pa_in[0] = P_W'(qy) * P_W'(v_in[2]);
      pa_in[1] = P_W'(qz) * P_W'(v_in[1]);
      pa_in[2] = P_W'(qz) * P_W'(v_in[0]);
      pa_in[3] = P_W'(qx) * P_W'(v_in[2]);
      pa_in[4] = P_W'(qx) * P_W'(v_in[1]);
      pa_in[5] = P_W'(qy) * P_W'(v_in[0]);
   end

   // stage 2: a = u x v
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_in[i] = A_W'((D_W'(pa_ff[2*i]) - D_W'(pa_ff[2*i+1])) >>> tlcrg_pkg::Q_FRAC);
      end
   end

   // stage 3: u x a terms and w*a
   always_comb begin
      pb_in[0] = PB_W'(qy) * PB_W'(a_ff[2]);
      pb_in[1] = PB_W'(qz) * PB_W'(a_ff[1]);
      pb_in[2] = PB_W'(qz) * PB_W'(a_ff[0]);
      pb_in[3] = PB_W'(qx) * PB_W'(a_ff[2]);
      pb_in[4] = PB_W'(qx) * PB_W'(a_ff[1]);
      pb_in[5] = PB_W'(qy) * PB_W'(a_ff[0]);
      for (int i = 0; i < 3; i++) begin
         wa_in[i] = PB_W'(qw) * PB_W'(a_ff[i]);
      end
   end

   // stage 4: combine
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         db[i]   = DB_W'(pb_ff[2*i]) - DB_W'(pb_ff[2*i+1]);
         r_in[i] = R_W'(v3_ff[i])
                 + ((R_W'(wa_ff[i] >>> tlcrg_pkg::Q_FRAC)
                   + R_W'(db[i] >>> tlcrg_pkg::Q_FRAC)) <<< 1);
      end
   end

   always_ff @(posedge clock) begin
      pa_ff <= pa_in;
      a_ff  <= a_in;
      pb_ff <= pb_in;
      wa_ff <= wa_in;
      r_ff  <= r_in;
      v1_ff <= v_in;
      v2_ff <= v1_ff;
      v3_ff <= v2_ff;
   end

   assign r_out = r_ff;

endmodule

// ===== src/thin_lens_camera_ray_generator_unit.sv =====
// Thin-lens camera primary ray generator, fully pipelined.
// Depends on tlcrg_pkg and tlcrg_rotate.
//
// Usage:
//  - Requests enter on req_data when start is high; busy is always low, so one
//    request is taken every cycle with no gaps needed.
//  - Each request yields one result on rsp_data, marked by a one-cycle
//    rsp_strobe, when it reaches the result register. Results leave in request
//    order. The receiver has no way to stall; it must take every strobe.
//  - Latency is mostly the 32-step square root (one result bit per stage)
//    and the 15-step restoring divider that follows it; the other stages
//    capture, multiply, sum, normalize, delay, set up the dividend or sign the result.
//  - CSR writes (csr_write, csr_index, csr_data) take effect at the next
//    edge; change them only while no request is in flight.
//  - Synchronous reset clears the valid chain and loads the register reset
//    values (identity rotation, everything else zero). No clearing pass.
//  - Origin path: lens sample -> rotate -> add camera position with
//    saturation, then a delay line to line up with the direction path.
//  - Direction path: pixel centre -> block normalize -> rotate -> block
//    normalize -> sum of squares -> sqrt -> per-axis rounded divide -> sign.
module thin_lens_camera_ray_generator_unit #(
   parameter int COORD_BITS = tlcrg_pkg::COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tlcrg_pkg::req_type   req_data,
   output logic                 rsp_strobe,
   output tlcrg_pkg::rsp_type   rsp_data,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_data
);

   localparam int NW         = tlcrg_pkg::NORM_W;
   localparam int CX_W       = COORD_BITS + 16;
   localparam int M_W        = CX_W + 33;
   localparam int L_W        = 33;
   localparam int LENS_W     = L_W - 6;
   localparam int RO_W       = LENS_W + 9;
   localparam int S_W        = RO_W + 1;
   localparam int VN_W       = 31;
   localparam int RD_W       = VN_W + 9;
   localparam int MG_W       = 30;
   localparam int SQ_W       = 64;
   localparam int LEN_W      = 31;
   localparam int N_W        = MG_W + 15;
   localparam int ROT_LAT    = 4;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 15;
   localparam int LAT        = 6 + ROT_LAT + 3 + 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;
   localparam int T_ORG      = 3 + ROT_LAT + 1;
   localparam int ORG_DLY    = LAT - T_ORG;
   localparam int T_DIV      = LAT - DIV_STEPS - 1;

   typedef struct packed {
      logic [2:0][MG_W-1:0] mg;
      logic [2:0]           sg;
      logic                 zero;
   } sq_tail_type;

   typedef struct packed {
      logic [2:0] sg;
      logic       zero;
   } div_tail_type;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ---------------- configuration registers ----------------
   logic [63:0]        rot_ff;
   logic signed [31:0] pos_ff [3];
   logic [47:0]        view_ff;
   logic signed [31:0] step_x_ff, step_y_ff;
   logic [15:0]        rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff    <= tlcrg_pkg::ROT_RESET;
         pos_ff    <= '{default: '0};
         view_ff   <= '0;
         step_x_ff <= '0;
         step_y_ff <= '0;
         rad_ff    <= '0;
      end else if (csr_write) begin
         unique case (tlcrg_pkg::csr_index_type'(csr_index))
            tlcrg_pkg::CSR_ROTATION:    rot_ff    <= csr_data;
            tlcrg_pkg::CSR_POS_X:       pos_ff[0] <= csr_data[31:0];
            tlcrg_pkg::CSR_POS_Y:       pos_ff[1] <= csr_data[31:0];
            tlcrg_pkg::CSR_POS_Z:       pos_ff[2] <= csr_data[31:0];
            tlcrg_pkg::CSR_VIEW_OFFSET: view_ff   <= csr_data[47:0];
            tlcrg_pkg::CSR_STEP_X:      step_x_ff <= csr_data[31:0];
            tlcrg_pkg::CSR_STEP_Y:      step_y_ff <= csr_data[31:0];
            tlcrg_pkg::CSR_DEFOCUS:     rad_ff    <= csr_data[15:0];
         endcase
      end
   end

   // valid chain, one bit per pipeline register stage
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // ---------------- t1: capture coordinates ----------------
   logic [CX_W-1:0]    cx_ff, cy_ff;
   logic signed [15:0] dx_ff, dy_ff;
   always_ff @(posedge clock) begin
      cx_ff <= {COORD_BITS'(req_data.pixel_col), req_data.jitter_x};
      cy_ff <= {COORD_BITS'(req_data.pixel_row), req_data.jitter_y};
      dx_ff <= req_data.disk_x;
      dy_ff <= req_data.disk_y;
   end

   // ---------------- t2: step and lens products ----------------
   logic signed [M_W-1:0] mx_ff, my_ff;
   logic signed [L_W-1:0] lx_ff, ly_ff;
   always_ff @(posedge clock) begin
      mx_ff <= M_W'($signed({1'b0, cx_ff})) * M_W'(step_x_ff);
      my_ff <= M_W'($signed({1'b0, cy_ff})) * M_W'(step_y_ff);
      lx_ff <= L_W'(dx_ff) * L_W'($signed({1'b0, rad_ff}));
      ly_ff <= L_W'(dy_ff) * L_W'($signed({1'b0, rad_ff}));
   end

   // ---------------- t3: pixel centre minus lens origin ----------------
   // zero radius gives zero products, so the pinhole case needs no mux
   logic signed [LENS_W-1:0] lens_in [2], lens_ff [2];
   logic signed [NW-1:0]     v_in [3], v_ff [3];
   always_comb begin
      lens_in[0] = LENS_W'(lx_ff >>> 6);
      lens_in[1] = LENS_W'(ly_ff >>> 6);
      v_in[0] = (NW'($signed(view_ff[15:0])) <<< 8) + NW'(mx_ff >>> 16) - NW'(lens_in[0]);
      v_in[1] = (NW'($signed(view_ff[31:16])) <<< 8) + NW'(my_ff >>> 16) - NW'(lens_in[1]);
      v_in[2] = NW'($signed(view_ff[47:32])) <<< 8;
   end
   always_ff @(posedge clock) begin
      lens_ff <= lens_in;
      v_ff    <= v_in;
   end

   // ---------------- origin path ----------------
   logic signed [LENS_W-1:0] lens_vec [3];
   logic signed [RO_W-1:0]   ro [3];
   assign lens_vec[0] = lens_ff[0];
   assign lens_vec[1] = lens_ff[1];
   assign lens_vec[2] = '0;

   tlcrg_rotate #(.IN_W(LENS_W)) u_rot_lens (
      .clock (clock),
      .quat  (rot_ff),
      .v_in  (lens_vec),
      .r_out (ro)
   );

   logic [2:0][31:0]      org_in;
   logic [2:0][31:0]      org_ff [ORG_DLY];
   logic signed [S_W-1:0] org_sum [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         org_sum[i] = S_W'(pos_ff[i]) + S_W'(ro[i]);
         if (org_sum[i] > S_W'(32'sh7FFF_FFFF)) begin
            org_in[i] = 32'h7FFF_FFFF;
         end else if (org_sum[i] < S_W'(32'sh8000_0000)) begin
            org_in[i] = 32'h8000_0000;
         end else begin
            org_in[i] = org_sum[i][31:0];
         end
      end
   end
   always_ff @(posedge clock) begin
      org_ff[0] <= org_in;
      for (int i = 1; i < ORG_DLY; i++) begin
         org_ff[i] <= org_ff[i-1];
      end
   end

   // ---------------- t4..t6: first block normalize ----------------
   logic signed [NW-1:0]              v4_ff [3];
   logic [tlcrg_pkg::POS_W-1:0]       p1_ff;
   logic signed [31:0]                vs_ff [3];
   logic signed [VN_W-1:0]            vn_in [3], vn_ff [3];
   logic                              edge1;
   always_comb begin
      edge1 = 1'b0;
      for (int i = 0; i < 3; i++) begin
         edge1 = edge1 || (vs_ff[i] == tlcrg_pkg::NORM_EDGE);
      end
      // a floored halving can land a negative value on -2^30: one more halving
      for (int i = 0; i < 3; i++) begin
         vn_in[i] = edge1 ? VN_W'(vs_ff[i] >>> 1) : VN_W'(vs_ff[i]);
      end
   end
   always_ff @(posedge clock) begin
      v4_ff <= v_ff;
      p1_ff <= tlcrg_pkg::lead_pos(tlcrg_pkg::mag_of(v_ff[0]) | tlcrg_pkg::mag_of(v_ff[1])
                                   | tlcrg_pkg::mag_of(v_ff[2]));
      for (int i = 0; i < 3; i++) begin
         vs_ff[i] <= tlcrg_pkg::norm_shift(v4_ff[i], p1_ff);
      end
      vn_ff <= vn_in;
   end

   // ---------------- t7..t10: rotate direction ----------------
   logic signed [RD_W-1:0] rd [3];
   tlcrg_rotate #(.IN_W(VN_W)) u_rot_dir (
      .clock (clock),
      .quat  (rot_ff),
      .v_in  (vn_ff),
      .r_out (rd)
   );

   // ---------------- t11..t13: second block normalize ----------------
   logic signed [NW-1:0]        r11_ff [3];
   logic [tlcrg_pkg::POS_W-1:0] p2_ff;
   logic [NW-1:0]               mor2;
   logic                        z11_ff, z12_ff, z13_ff;
   logic signed [31:0]          rs_ff [3];
   logic signed [VN_W-1:0]      nr_in [3], nr_ff [3];
   logic                        edge2;
   assign mor2 = tlcrg_pkg::mag_of(NW'(rd[0])) | tlcrg_pkg::mag_of(NW'(rd[1]))
               | tlcrg_pkg::mag_of(NW'(rd[2]));
   always_comb begin
      edge2 = 1'b0;
      for (int i = 0; i < 3; i++) begin
         edge2 = edge2 || (rs_ff[i] == tlcrg_pkg::NORM_EDGE);
      end
      for (int i = 0; i < 3; i++) begin
         nr_in[i] = edge2 ? VN_W'(rs_ff[i] >>> 1) : VN_W'(rs_ff[i]);
      end
   end
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         r11_ff[i] <= NW'(rd[i]);
         rs_ff[i]  <= tlcrg_pkg::norm_shift(r11_ff[i], p2_ff);
      end
      p2_ff  <= tlcrg_pkg::lead_pos(mor2);
      z11_ff <= (mor2 == '0);
      z12_ff <= z11_ff;
      nr_ff  <= nr_in;
      z13_ff <= z12_ff;
   end

   // ---------------- t14..t15: sum of squares ----------------
   logic [2:0][MG_W-1:0]   mg14_ff;
   logic [2:0]             sg14_ff;
   logic [2*MG_W-1:0]      sq14_ff [3];
   logic                   z14_ff;
   logic [MG_W-1:0]        mg14_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mg14_in[i] = nr_ff[i][VN_W-1] ? MG_W'(-nr_ff[i]) : MG_W'(nr_ff[i]);
      end
   end

   logic [SQ_W-1:0] sx_ff [SQRT_STEPS+1];
   logic [SQ_W-1:0] sr_ff [SQRT_STEPS+1];
   sq_tail_type     st_ff [SQRT_STEPS+1];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mg14_ff[i] <= mg14_in[i];
         sg14_ff[i] <= nr_ff[i][VN_W-1];
         sq14_ff[i] <= (2*MG_W)'(mg14_in[i]) * (2*MG_W)'(mg14_in[i]);
      end
      z14_ff   <= z13_ff;
      sx_ff[0] <= SQ_W'(sq14_ff[0]) + SQ_W'(sq14_ff[1]) + SQ_W'(sq14_ff[2]);
      sr_ff[0] <= '0;
      st_ff[0] <= '{mg: mg14_ff, sg: sg14_ff, zero: z14_ff};
   end

   // ---------------- square root, one result bit per stage ----------------
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [SQ_W-1:0] trial, x_nx, r_nx;
      always_comb begin
         trial = sr_ff[k] + BIT;
         if (sx_ff[k] >= trial) begin
            x_nx = sx_ff[k] - trial;
            r_nx = (sr_ff[k] >> 1) + BIT;
         end else begin
            x_nx = sx_ff[k];
            r_nx = sr_ff[k] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         sx_ff[k+1] <= x_nx;
         sr_ff[k+1] <= r_nx;
         st_ff[k+1] <= st_ff[k];
      end
   end

   // ---------------- t48: dividend set-up ----------------
   // quotient = (mag * 2^14 + len/2) / len, rounded half up on magnitudes
   logic [LEN_W-1:0]     len;
   logic [N_W-1:0]       num [3];
   logic [2:0][LEN_W-1:0] rem_ff [DIV_STEPS+1];
   logic [2:0][DIV_STEPS-1:0] nl_ff [DIV_STEPS+1];
   logic [2:0][DIV_STEPS-1:0] q_ff [DIV_STEPS+1];
   logic [LEN_W-1:0]     dv_ff [DIV_STEPS+1];
   div_tail_type         dt_ff [DIV_STEPS+1];

   assign len = sr_ff[SQRT_STEPS][LEN_W-1:0];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = {st_ff[SQRT_STEPS].mg[i], 15'd0} >> 1;
         num[i] = N_W'({st_ff[SQRT_STEPS].mg[i], 14'd0}) + N_W'(len >> 1);
      end
   end
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         rem_ff[0][i] <= LEN_W'(num[i][N_W-1:DIV_STEPS]);
         nl_ff[0][i]  <= num[i][DIV_STEPS-1:0];
      end
      q_ff[0]  <= '0;
      dv_ff[0] <= len;
      dt_ff[0] <= '{sg: st_ff[SQRT_STEPS].sg, zero: st_ff[SQRT_STEPS].zero};
   end

   // ---------------- restoring divider, one quotient bit per stage ----------------
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int B = DIV_STEPS - 1 - j;
      logic [LEN_W:0]              trial [3];
      logic [2:0][LEN_W-1:0]       rem_nx;
      logic [2:0][DIV_STEPS-1:0]   q_nx;
      always_comb begin
         q_nx = q_ff[j];
         for (int i = 0; i < 3; i++) begin
            trial[i] = {rem_ff[j][i], nl_ff[j][i][B]};
            if (trial[i] >= {1'b0, dv_ff[j]}) begin
               rem_nx[i]  = LEN_W'(trial[i] - {1'b0, dv_ff[j]});
               q_nx[i][B] = 1'b1;
            end else begin
               rem_nx[i] = LEN_W'(trial[i]);
            end
         end
      end
      always_ff @(posedge clock) begin
         rem_ff[j+1] <= rem_nx;
         q_ff[j+1]   <= q_nx;
         nl_ff[j+1]  <= nl_ff[j];
         dv_ff[j+1]  <= dv_ff[j];
         dt_ff[j+1]  <= dt_ff[j];
      end
   end

   // ---------------- t64: result register ----------------
   logic [15:0] dir_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dt_ff[DIV_STEPS].zero) begin
            dir_in[i] = '0;
         end else if (dt_ff[DIV_STEPS].sg[i]) begin
            dir_in[i] = -16'(q_ff[DIV_STEPS][i]);
         end else begin
            dir_in[i] = 16'(q_ff[DIV_STEPS][i]);
         end
      end
   end

   tlcrg_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      rsp_ff.origin_x <= org_ff[ORG_DLY-1][0];
      rsp_ff.origin_y <= org_ff[ORG_DLY-1][1];
      rsp_ff.origin_z <= org_ff[ORG_DLY-1][2];
      rsp_ff.dir_x    <= dir_in[0];
      rsp_ff.dir_y    <= dir_in[1];
      rsp_ff.dir_z    <= dir_in[2];
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = vld_ff[LAT-1];

   // ---------------- assertions ----------------
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LAT) rsp_strobe)
      else $error("request did not produce a result after the pipeline latency");

   a_len_norm : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[T_DIV-1] && !dt_ff[0].zero) |-> (dv_ff[0] >= LEN_W'(32'd1 << 29)))
      else $error("vector length below normalized range at divider input");

   a_dir_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.dir_x <= 16'sd16384) && (rsp_data.dir_x >= -16'sd16384)
                   && (rsp_data.dir_y <= 16'sd16384) && (rsp_data.dir_y >= -16'sd16384)
                   && (rsp_data.dir_z <= 16'sd16384) && (rsp_data.dir_z >= -16'sd16384)))
      else $error("direction component exceeds unit magnitude");

endmodule
